// ----- sv/x86e_pkg.sv -----
// Package with opcodes, register indexes and flag masks for the instruction executor.
`default_nettype none
package x86e_pkg;

  localparam int STACK_BYTES_DEF = 1024;
  localparam int PC_BITS_DEF     = 16;
  localparam int REG_COUNT       = 17;
  localparam int REG_IDX_BITS    = 5;
  localparam int WORD_BITS       = 32;

  localparam logic [4:0] SP_REG   = 5'd6;
  localparam logic [4:0] FLAG_REG = 5'd16;

  localparam logic [31:0] ZF_MASK = 32'h0000_0040;
  localparam logic [31:0] SF_MASK = 32'h0000_0080;
  localparam logic [31:0] CF_MASK = 32'h0000_0001;
  localparam logic [31:0] OF_MASK = 32'h0000_0800;

  localparam logic [4:0] OP_SUBI  = 5'd0;
  localparam logic [4:0] OP_ADD   = 5'd1;
  localparam logic [4:0] OP_ADDI  = 5'd2;
  localparam logic [4:0] OP_MUL   = 5'd3;
  localparam logic [4:0] OP_SHR   = 5'd4;
  localparam logic [4:0] OP_MOV   = 5'd5;
  localparam logic [4:0] OP_LOAD  = 5'd6;
  localparam logic [4:0] OP_STORE = 5'd7;
  localparam logic [4:0] OP_MOVI  = 5'd8;
  localparam logic [4:0] OP_CMP   = 5'd9;
  localparam logic [4:0] OP_JE    = 5'd10;
  localparam logic [4:0] OP_JL    = 5'd11;
  localparam logic [4:0] OP_JLE   = 5'd12;
  localparam logic [4:0] OP_JGE   = 5'd13;
  localparam logic [4:0] OP_JBE   = 5'd14;
  localparam logic [4:0] OP_JMP   = 5'd15;
  localparam logic [4:0] OP_CALL  = 5'd16;
  localparam logic [4:0] OP_RET   = 5'd17;
  localparam logic [4:0] OP_PUSH  = 5'd18;
  localparam logic [4:0] OP_POP   = 5'd19;
  localparam logic [4:0] OP_PRINT = 5'd20;
  localparam logic [4:0] OP_READ  = 5'd21;

endpackage
`default_nettype wire

// ----- sv/x86e_stack_mem.sv -----
// Word-addressed stack memory with one registered read port and a clearing pass after reset.
`default_nettype none
module x86e_stack_mem #(
  parameter int STACK_BYTES = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(STACK_BYTES/4)-1:0] wr_addr,
  input  wire logic [31:0]                       wr_data,
  input  wire logic [$clog2(STACK_BYTES/4)-1:0] rd_addr,
  output logic      [31:0]                       rd_data,
  output logic                                   busy
);
  import x86e_pkg::*;

  localparam int WORDS = STACK_BYTES / 4;
  localparam int AW    = $clog2(WORDS);

  logic [31:0]   mem [WORDS];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  // Clearing sweep, one word per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port shared by the sweep and the executor.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing;
endmodule
`default_nettype wire

// ----- sv/x86_subset_instruction_executor_top.sv -----
// Top level of the x86-subset instruction executor.
// Usage: the host sends one item on s_axis: tdata[31:0] is the instruction word fetched
// at the last reported next_pc, tdata[63:32] the value for the read opcode. Each item
// yields exactly one item on m_axis: tdata[15:0] next_pc, [47:16] print_value,
// tuser[0] print_valid, [1] halted, [2] fault.
// The user must write program_end (cfg_wr_en/cfg_wr_data) only while idle; unenforced.
// Steps: on acceptance the item is decoded, the stack memory is read at the addressed
// word and ex_word/ex_read capture the item; the execute step then takes that word,
// updates the register file, pc and stack, and loads the output register or the skid
// entry. A new item is not accepted while one is in the execute step.
// Reset: pc, flags and registers clear (stack pointer to STACK_BYTES); the stack memory
// is then swept clear word by word, during which s_axis_tready stays low.
// Stall: the result waits in the output register; a new item is still accepted and
// executed while a skid register holds space for its result, so no item is lost.
`default_nettype none
module x86_subset_instruction_executor_top #(
  parameter int STACK_BYTES = x86e_pkg::STACK_BYTES_DEF,
  parameter int PC_BITS     = x86e_pkg::PC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // instr_word[31:0], read_value[63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // next_pc[15:0], print_value[47:16]
  output logic      [2:0]  m_axis_tuser,  // print_valid[0], halted[1], fault[2]
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data    // program_end
);
  import x86e_pkg::*;

  localparam int WORDS = STACK_BYTES / 4;
  localparam int AW    = $clog2(WORDS);

  typedef struct packed {
    logic [15:0] next_pc;
    logic [31:0] print_value;
    logic        print_valid;
    logic        halted;
    logic        fault;
  } result_t;

  // Architectural state.
  logic [PC_BITS-1:0] pc;
  logic               halt_flag;
  logic [15:0]        program_end;
  logic [31:0]        regs [REG_COUNT];

  // Stage registers for the item being executed.
  logic        busy;
  logic [31:0] ex_word;
  logic [31:0] ex_read;

  // Output register and skid entry.
  result_t out_q, skid_q;
  logic    out_v, skid_v;

  logic          mem_busy;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic accept, finish;

  // An item enters when not clearing, no item is in flight and the skid slot is free.
  assign s_axis_tready = !mem_busy && !busy && !skid_v;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign finish        = busy;

  // Decode of the incoming item to address the stack read.
  logic [4:0]  in_op;
  logic [31:0] in_imm, in_sp, in_addr;
  always_comb begin
    in_op  = s_axis_tdata[31:27];
    in_imm = {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
    in_sp  = regs[SP_REG];
    in_addr = (in_op == OP_LOAD) ? in_sp - (in_imm << 2) : in_sp;
    mem_raddr = in_addr[AW+1:2];
  end

  x86e_stack_mem #(.STACK_BYTES(STACK_BYTES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .busy    (mem_busy)
  );

  // Execute stage decode.
  logic [4:0]  op, ra, rb;
  logic [31:0] imm, va, vb, sp, fl, addr;
  logic [PC_BITS-1:0] npc, jpc, pc_next;
  logic        lt, use_a, use_b, bad_reg, bad_stack, take;
  logic        halt_next, reg_we, sp_we;
  logic [4:0]  reg_wi;
  logic [31:0] reg_wd, sp_wd;
  logic [32:0] diff;
  result_t     res;

  function automatic logic stack_ok(input logic [31:0] a);
    return (a[1:0] == 2'b00) && (a <= 32'(STACK_BYTES - 4));
  endfunction

  always_comb begin
    op  = ex_word[31:27];
    ra  = ex_word[26:22];
    rb  = ex_word[21:17];
    imm = {{16{ex_word[15]}}, ex_word[15:0]};
    va  = (ra < 5'(REG_COUNT)) ? regs[ra[4:0]] : '0;
    vb  = (rb < 5'(REG_COUNT)) ? regs[rb[4:0]] : '0;
    sp  = regs[SP_REG];
    fl  = regs[FLAG_REG];
    lt  = ((fl & SF_MASK) != 0) != ((fl & OF_MASK) != 0);
    npc = pc + PC_BITS'(4);
    jpc = pc + imm[PC_BITS-1:0] + PC_BITS'(4);
    use_a = (op <= OP_MOVI && op != OP_LOAD) || op == OP_CMP ||
            (op >= OP_PUSH && op <= OP_READ);
    use_b = op == OP_ADD || op == OP_MUL || op == OP_MOV || op == OP_LOAD || op == OP_CMP;
    bad_reg = (use_a && ra >= 5'(REG_COUNT)) || (use_b && rb >= 5'(REG_COUNT));
    diff = {1'b0, vb} - {1'b0, va};

    addr = sp;
    unique case (op)
      OP_LOAD, OP_STORE:           addr = sp - (imm << 2);
      OP_CALL, OP_PUSH:            addr = sp - 32'd4;
      default:                     addr = sp;
    endcase
    bad_stack = 1'b0;
    if (op inside {OP_LOAD, OP_STORE, OP_CALL, OP_PUSH, OP_POP}) begin
      bad_stack = !stack_ok(addr);
    end else if (op == OP_RET) begin
      bad_stack = (sp != 32'(STACK_BYTES)) && !stack_ok(sp);
    end

    take = 1'b0;
    unique case (op)
      OP_JE:   take = (fl & ZF_MASK) != 0;
      OP_JL:   take = lt;
      OP_JLE:  take = lt || ((fl & ZF_MASK) != 0);
      OP_JGE:  take = !lt;
      OP_JBE:  take = (fl & (ZF_MASK | CF_MASK)) != 0;
      OP_JMP, OP_CALL: take = 1'b1;
      default: take = 1'b0;
    endcase

    reg_we = 1'b0; reg_wi = ra; reg_wd = '0;
    sp_we = 1'b0; sp_wd = '0;
    mem_we = 1'b0; mem_waddr = addr[AW+1:2]; mem_wdata = va;
    pc_next = take ? jpc : npc;
    halt_next = halt_flag;
    res.print_valid = 1'b0;
    res.print_value = '0;
    res.fault = 1'b0;

    if (halt_flag || 32'(pc) == 32'(program_end)) begin
      halt_next = 1'b1;
      pc_next = pc;
    end else if (bad_reg || bad_stack) begin
      res.fault = 1'b1;
      pc_next = pc;
    end else if (op == OP_RET && sp == 32'(STACK_BYTES)) begin
      halt_next = 1'b1;
      pc_next = pc;
    end else begin
      unique case (op)
        OP_SUBI:  begin reg_we = 1'b1; reg_wd = va - imm; end
        OP_ADD:   begin reg_we = 1'b1; reg_wi = rb; reg_wd = va + vb; end
        OP_ADDI:  begin reg_we = 1'b1; reg_wd = va + imm; end
        OP_MUL:   begin reg_we = 1'b1; reg_wi = rb; reg_wd = va * vb; end
        OP_SHR:   begin reg_we = 1'b1; reg_wd = va >> 1; end
        OP_MOV:   begin reg_we = 1'b1; reg_wi = rb; reg_wd = va; end
        OP_LOAD:  begin reg_we = 1'b1; reg_wi = rb; reg_wd = mem_rdata; end
        OP_STORE: mem_we = 1'b1;
        OP_MOVI:  begin reg_we = 1'b1; reg_wd = imm; end
        OP_CMP: begin
          reg_we = 1'b1; reg_wi = FLAG_REG;
          reg_wd = '0;
          if (diff[31:0] == 0) reg_wd = reg_wd | ZF_MASK;
          if (diff[31]) reg_wd = reg_wd | SF_MASK;
          if (vb < va) reg_wd = reg_wd | CF_MASK;
          if ((vb[31] != va[31]) && (diff[31] != vb[31])) reg_wd = reg_wd | OF_MASK;
        end
        OP_CALL: begin
          mem_we = 1'b1; mem_wdata = 32'(npc);
          sp_we = 1'b1; sp_wd = addr;
        end
        OP_RET: begin
          pc_next = mem_rdata[PC_BITS-1:0];
          sp_we = 1'b1; sp_wd = sp + 32'd4;
        end
        OP_PUSH: begin
          mem_we = 1'b1; sp_we = 1'b1; sp_wd = addr;
        end
        OP_POP: begin
          reg_we = 1'b1;
          if (ra == SP_REG) begin
            // Popping into the stack pointer leaves the loaded word plus four.
            reg_wd = mem_rdata + 32'd4;
          end else begin
            reg_wd = mem_rdata;
            sp_we = 1'b1; sp_wd = sp + 32'd4;
          end
        end
        OP_PRINT: begin res.print_valid = 1'b1; res.print_value = va; end
        OP_READ:  begin reg_we = 1'b1; reg_wd = ex_read; end
        default: ;
      endcase
      if (32'(pc_next) == 32'(program_end)) halt_next = 1'b1;
    end
    if (!finish) mem_we = 1'b0;
    res.next_pc = 16'(pc_next);
    res.halted  = halt_next;
  end

  // Execute stage control and architectural updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= '0;
      halt_flag <= 1'b0;
      program_end <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= (i == int'(SP_REG)) ? 32'(STACK_BYTES) : '0;
      end
    end else begin
      if (cfg_wr_en) program_end <= cfg_wr_data;
      if (accept) begin
        busy <= 1'b1;
        ex_word <= s_axis_tdata[31:0];
        ex_read <= s_axis_tdata[63:32];
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        pc <= pc_next;
        halt_flag <= halt_next;
        if (sp_we) regs[SP_REG] <= sp_wd;
        if (reg_we) regs[reg_wi] <= reg_wd;
      end
    end
  end

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!out_v || m_axis_tready) begin
        if (skid_v) begin
          out_q <= skid_q; out_v <= 1'b1; skid_v <= 1'b0;
          if (finish) begin skid_q <= res; skid_v <= 1'b1; end
        end else if (finish) begin
          out_q <= res; out_v <= 1'b1;
        end else begin
          out_v <= 1'b0;
        end
      end else if (finish) begin
        skid_q <= res; skid_v <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {out_q.print_value, out_q.next_pc};
  assign m_axis_tuser  = {out_q.fault, out_q.halted, out_q.print_valid};

  // No item is taken while the stack is still being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !s_axis_tready) else $error("item accepted during stack clear");
  // Every accepted item finishes in the next cycle.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    accept |=> finish) else $error("item did not finish");
  // A finished result never overruns a full skid entry.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    finish |-> !skid_v) else $error("result overrun");
  // A fault leaves the program counter where it was.
  a_fault_pc: assert property (@(posedge clk) disable iff (rst)
    (finish && res.fault) |=> $stable(pc)) else $error("pc moved on fault");
endmodule
`default_nettype wire

// ----- tb/executor_checker.sv -----
// Checker that predicts and compares every result of the instruction executor.
`default_nettype none
module executor_checker
  import x86e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output int               fail_count,
  output int               pending,
  output int               results_seen,
  output logic      [15:0] model_pc
);

  localparam logic [31:0] STACK_TOP = 32'(STACK_BYTES_DEF);

  typedef struct packed {
    logic [15:0] next_pc;
    logic [31:0] print_value;
    logic        print_valid;
    logic        halted;
    logic        fault;
  } step_result_t;

  // Architectural state as the executor should hold it.
  logic [15:0] pc;
  logic [31:0] regs [REG_COUNT];
  logic [31:0] stack_mem [STACK_BYTES_DEF/4];
  logic        halted;
  logic [15:0] prog_end;

  step_result_t expected_results [$];

  initial begin
    fail_count   = 0;
    results_seen = 0;
    pending      = 0;
    model_pc     = '0;
  end

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic reset_model();
    pc       = '0;
    halted   = 1'b0;
    prog_end = '0;
    for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
    regs[SP_REG] = STACK_TOP;
    for (int i = 0; i < STACK_BYTES_DEF/4; i++) stack_mem[i] = '0;
  endtask

  function automatic logic addr_ok(input logic [31:0] addr);
    return addr[1:0] == 2'b00 && addr <= STACK_TOP - 4;
  endfunction

  // Executes one instruction on the model state and returns its result.
  task automatic execute(input logic [31:0] w, input logic [31:0] rd_val,
                         output step_result_t res);
    logic [4:0]  op, ra, rb;
    logic [31:0] imm, sp, fl, addr, x, y, f;
    logic [15:0] npc, jpc;
    logic [32:0] sd;
    logic        lt, use_a, use_b, flt;
    op   = w[31:27];
    ra   = w[26:22];
    rb   = w[21:17];
    imm  = {{16{w[15]}}, w[15:0]};
    npc  = pc + 16'd4;
    jpc  = pc + imm[15:0] + 16'd4;
    sp   = regs[SP_REG];
    fl   = regs[FLAG_REG];
    lt   = ((fl & SF_MASK) != 0) != ((fl & OF_MASK) != 0);
    use_a = op <= OP_MOV || op == OP_STORE || op == OP_MOVI || op == OP_CMP ||
            (op >= OP_PUSH && op <= OP_READ);
    use_b = op == OP_ADD || op == OP_MUL || op == OP_MOV || op == OP_LOAD || op == OP_CMP;
    flt  = 1'b0;
    res  = '0;
    if (halted || pc == prog_end) begin
      halted = 1'b1;
      npc    = pc;
    end else if ((use_a && ra >= REG_COUNT) || (use_b && rb >= REG_COUNT)) begin
      flt = 1'b1;
      npc = pc;
    end else begin
      case (op)
        OP_SUBI: regs[ra] = regs[ra] - imm;
        OP_ADD:  regs[rb] = regs[ra] + regs[rb];
        OP_ADDI: regs[ra] = regs[ra] + imm;
        OP_MUL:  regs[rb] = regs[ra] * regs[rb];
        OP_SHR:  regs[ra] = regs[ra] >> 1;
        OP_MOV:  regs[rb] = regs[ra];
        OP_LOAD, OP_STORE: begin
          addr = sp - imm * 4;
          if (!addr_ok(addr)) flt = 1'b1;
          else if (op == OP_LOAD) regs[rb] = stack_mem[addr[9:2]];
          else stack_mem[addr[9:2]] = regs[ra];
        end
        OP_MOVI: regs[ra] = imm;
        OP_CMP: begin
          x  = regs[rb];
          y  = regs[ra];
          sd = $signed({x[31], x}) - $signed({y[31], y});
          f  = '0;
          if (x - y == 0) f |= ZF_MASK;
          if (sd[31]) f |= SF_MASK;
          if (x < y) f |= CF_MASK;
          if (sd[32] != sd[31]) f |= OF_MASK;
          regs[FLAG_REG] = f;
        end
        OP_JE:  if ((fl & ZF_MASK) != 0) npc = jpc;
        OP_JL:  if (lt) npc = jpc;
        OP_JLE: if (lt || (fl & ZF_MASK) != 0) npc = jpc;
        OP_JGE: if (!lt) npc = jpc;
        OP_JBE: if ((fl & (ZF_MASK | CF_MASK)) != 0) npc = jpc;
        OP_JMP: npc = jpc;
        OP_CALL: begin
          addr = sp - 4;
          if (!addr_ok(addr)) flt = 1'b1;
          else begin
            stack_mem[addr[9:2]] = {16'd0, npc};
            regs[SP_REG] = addr;
            npc = jpc;
          end
        end
        OP_RET: begin
          if (sp == STACK_TOP) halted = 1'b1;
          else if (!addr_ok(sp)) flt = 1'b1;
          else begin
            npc = stack_mem[sp[9:2]][15:0];
            regs[SP_REG] = sp + 4;
          end
        end
        OP_PUSH: begin
          addr = sp - 4;
          if (!addr_ok(addr)) flt = 1'b1;
          else begin
            stack_mem[addr[9:2]] = regs[ra];
            regs[SP_REG] = addr;
          end
        end
        OP_POP: begin
          if (!addr_ok(sp)) flt = 1'b1;
          else begin
            regs[ra] = stack_mem[sp[9:2]];
            regs[SP_REG] = regs[SP_REG] + 4;
          end
        end
        OP_PRINT: begin
          res.print_valid = 1'b1;
          res.print_value = regs[ra];
        end
        OP_READ: regs[ra] = rd_val;
        default: ;
      endcase
      // A ret at the empty stack and a faulting access leave pc where it was.
      if (flt || halted) npc = pc;
      else begin
        pc = npc;
        if (pc == prog_end) halted = 1'b1;
      end
    end
    res.next_pc = npc;
    res.halted  = halted;
    res.fault   = flt;
  endtask

  // Track configuration, predict accepted items and compare results.
  always @(posedge clk) begin
    step_result_t r, e;
    if (rst) begin
      reset_model();
      expected_results.delete();
    end else begin
      if (cfg_wr_en) prog_end = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        execute(s_axis_tdata[31:0], s_axis_tdata[63:32], r);
        expected_results.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report("unexpected result", m_axis_tdata, '0);
        end else begin
          e = expected_results.pop_front();
          if (m_axis_tdata[15:0] != e.next_pc)
            report("next_pc", m_axis_tdata[15:0], e.next_pc);
          if (m_axis_tdata[47:16] != e.print_value)
            report("print_value", m_axis_tdata[47:16], e.print_value);
          if (m_axis_tuser[0] != e.print_valid)
            report("print_valid", m_axis_tuser[0], e.print_valid);
          if (m_axis_tuser[1] != e.halted)
            report("halted", m_axis_tuser[1], e.halted);
          if (m_axis_tuser[2] != e.fault)
            report("fault", m_axis_tuser[2], e.fault);
        end
      end
    end
    pending  <= expected_results.size();
    model_pc <= pc;
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the executor testbench: clock, reset, stimulus, back-pressure and verdict.
`default_nettype none
module testbench;
  import x86e_pkg::*;

  localparam int RANDOM_PER_PHASE = 380;
  localparam int PHASES           = 5;
  localparam int CYCLE_LIMIT      = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int          fail_count, pending, results_seen;
  logic [15:0] model_pc;

  // Stimulus bookkeeping: call/push depth keeps ret away from the empty stack.
  int depth = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  x86_subset_instruction_executor_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  executor_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .model_pc      (model_pc)
  );

  // Receiver: random stalls, quiet stretches, and long hold-offs on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= 300;
      hold_done <= hold_done + 1;
    end else begin
      m_axis_tready <= quiet || $urandom_range(0, 99) >= 7;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] enc(input logic [4:0] op, input logic [4:0] ra,
                                      input logic [4:0] rb, input logic [15:0] imm);
    return {op, ra, rb, 1'b0, imm};
  endfunction

  // Keeps the stack depth seen by the stimulus in step with the block.
  task automatic note_stack(input logic [31:0] w);
    logic [4:0] op;
    op = w[31:27];
    if (op == OP_CALL || (op == OP_PUSH && w[26:22] < REG_COUNT)) begin
      if (depth < STACK_BYTES_DEF/4) depth++;
    end else if (op == OP_RET || (op == OP_POP && w[26:22] < REG_COUNT)) begin
      if (depth > 0) depth--;
    end
  endtask

  task automatic send(input logic [31:0] w, input logic [31:0] rd_val);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 7) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note_stack(w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rd_val, w};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_prog_end(input logic [15:0] v);
    // Never park the end marker on the current pc, which would halt at once.
    if (v == model_pc) v = v + 16'd4;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random instruction; mostly well-formed, sometimes bad registers or unused opcodes.
  task automatic send_random();
    logic [4:0]  op, ra, rb;
    logic [15:0] imm;
    op  = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, 21)) :
                                         5'($urandom_range(22, 31));
    ra  = ($urandom_range(0, 99) < 92) ? 5'($urandom_range(0, 16)) :
                                         5'($urandom_range(17, 31));
    rb  = ($urandom_range(0, 99) < 92) ? 5'($urandom_range(0, 16)) :
                                         5'($urandom_range(17, 31));
    imm = 16'($urandom_range(0, 16'hffff));
    case (op)
      OP_LOAD, OP_STORE:
        if ($urandom_range(0, 3) != 0) imm = 16'($urandom_range(0, depth + 1));
      OP_JE, OP_JL, OP_JLE, OP_JGE, OP_JBE, OP_JMP, OP_CALL:
        if ($urandom_range(0, 3) != 0) imm = 16'($signed($urandom_range(0, 128)) - 64);
      OP_RET:
        if (depth == 0) op = 5'd23;
      default: ;
    endcase
    // The stack pointer is only moved by the stack instructions.
    if ((op <= OP_MOVI && op != OP_STORE && op != OP_ADD && op != OP_MUL && op != OP_MOV &&
         op != OP_LOAD && ra == SP_REG) ||
        ((op == OP_POP || op == OP_READ) && ra == SP_REG))
      ra = 5'd7;
    if ((op == OP_ADD || op == OP_MUL || op == OP_MOV || op == OP_LOAD) && rb == SP_REG)
      rb = 5'd7;
    send(enc(op, ra, rb, imm), $urandom);
  endtask

  initial begin
    logic [15:0] ends [PHASES];
    ends = '{16'd65532, 16'd0, 16'd40000, 16'd65532, 16'd1000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_prog_end(16'd65532);

    // Directed part: every opcode, field extremes, faults and flag cases.
    quiet = 1'b1;
    send(enc(OP_MOVI, 5'd1, 5'd0, 16'h7fff), 0);
    send(enc(OP_MOVI, 5'd2, 5'd0, 16'h8000), 0);
    send(enc(OP_SUBI, 5'd3, 5'd0, 16'h8000), 0);
    send(enc(OP_ADDI, 5'd4, 5'd0, 16'h7fff), 0);
    send(enc(OP_ADD, 5'd1, 5'd2, 16'h0), 0);
    send(enc(OP_MUL, 5'd4, 5'd3, 16'h0), 0);
    send(enc(OP_SHR, 5'd2, 5'd0, 16'h0), 0);
    send(enc(OP_MOV, 5'd2, 5'd5, 16'h0), 0);
    send(enc(OP_STORE, 5'd1, 5'd0, 16'd1), 0);
    send(enc(OP_LOAD, 5'd0, 5'd7, 16'd1), 0);
    send(enc(OP_STORE, 5'd1, 5'd0, 16'hffff), 0);       // beyond the stack top
    send(enc(OP_CMP, 5'd1, 5'd2, 16'h0), 0);
    send(enc(OP_JE, 5'd0, 5'd0, 16'd8), 0);
    send(enc(OP_JL, 5'd0, 5'd0, 16'd8), 0);
    send(enc(OP_JLE, 5'd0, 5'd0, 16'hfff8), 0);
    send(enc(OP_JGE, 5'd0, 5'd0, 16'd8), 0);
    send(enc(OP_JBE, 5'd0, 5'd0, 16'd8), 0);
    send(enc(OP_CALL, 5'd0, 5'd0, 16'h7fff), 0);
    send(enc(OP_PUSH, 5'd5, 5'd0, 16'h0), 0);
    send(enc(OP_POP, 5'd8, 5'd0, 16'h0), 0);
    send(enc(OP_RET, 5'd0, 5'd0, 16'h0), 0);
    send(enc(OP_JMP, 5'd0, 5'd0, 16'h8000), 0);
    send(enc(OP_READ, 5'd9, 5'd0, 16'h0), 32'h8000_0000);
    send(enc(OP_READ, 5'd10, 5'd0, 16'h0), 32'h7fff_ffff);
    send(enc(OP_PRINT, 5'd9, 5'd0, 16'h0), 0);
    send(enc(OP_ADD, 5'd31, 5'd1, 16'h0), 0);            // bad first register
    send(enc(OP_MOV, 5'd1, 5'd17, 16'h0), 0);            // bad second register
    send(enc(5'd31, 5'd31, 5'd31, 16'hffff), 32'hffff_ffff);
    // Misaligned stack pointer, then put it back.
    send(enc(OP_ADDI, SP_REG, 5'd0, 16'd2), 0);
    send(enc(OP_LOAD, 5'd0, 5'd1, 16'd0), 0);
    send(enc(OP_SUBI, SP_REG, 5'd0, 16'd2), 0);

    // Random phases with different end markers and back-pressure patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_prog_end(ends[ph]);
      quiet = (ph == 1);
      if (ph == 2) hold_reqs++;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
    end

    // Finish by landing on the end marker, then run into the halted state.
    wait_idle();
    write_prog_end(model_pc + 16'd4);
    send(enc(5'd22, 5'd0, 5'd0, 16'h0), 0);
    send(enc(OP_MOVI, 5'd1, 5'd0, 16'h1234), 0);
    send(enc(OP_RET, 5'd0, 5'd0, 16'h0), 0);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d instructions over %0d phases with stalls and a long output hold-off.",
             items_sent, PHASES);
    $display("Compared %0d results; finished in the halted state.", results_seen);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/x86e_pkg.sv
sv/x86e_stack_mem.sv
sv/x86_subset_instruction_executor_top.sv
tb/executor_checker.sv
tb/testbench.sv
